/* design/cpsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cpsd_pkg;

    // Framing bytes
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    // Packet head storage: type byte plus two 32-bit singles
    localparam int         HEAD_DEPTH = 9;
    localparam int         LEN_W      = 4;
    localparam logic [3:0] HEAD_LEN   = 4'd9;
    localparam logic [3:0] LEN_MAX    = 4'd15;

    // Single-precision fields
    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0] EXP_BIAS     = 8'd127;
    localparam logic [7:0] EXP_FRAC_POS = 8'd150;
    localparam int         PROD_W       = 40;

    // Configuration register indexes and reset values
    localparam logic [1:0]  REG_SET_CODE = 2'd0;
    localparam logic [1:0]  REG_OFFSET   = 2'd1;
    localparam logic [1:0]  REG_SCALE    = 2'd2;
    localparam logic [7:0]  RST_SET_CODE = 8'd0;
    localparam logic [15:0] RST_OFFSET   = 16'd800;
    localparam logic [15:0] RST_SCALE    = 16'd1350;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_TYPE  = 2'd2,
        ST_SHORT = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] x_compare;
        logic [16:0] y_compare;
    } t_result;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [15:0] wr_data;
    } t_cfg_beat;

    // What the framer hands to the decode pipeline for one packet end
    typedef struct packed {
        logic        done;
        t_status     status;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
    } t_frame;

endpackage

`default_nettype wire

/* design/cpsd_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cpsd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/crlf_packet_servo_setpoint_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Servo set-point packet decoder. Takes one received serial byte per beat on
// i_rx and cuts the stream into packets ending at CR followed by LF; the
// previous byte is remembered across packets. Byte 0 of a packet is the type,
// bytes 1..4 and 5..8 are big-endian IEEE singles x and y; later bytes are
// counted but not kept. Every packet end yields exactly one result beat on
// o_res: status 0 with compare = offset + trunc(scale * value) for both
// channels when the type matches, nine bytes arrived and both values lie in
// 0..1 (-0 and positive subnormals pass, NaN and infinity do not); else
// status 2 (wrong type), 3 (too short) or 1 (out of range), tested in that
// order, with both compares zero. A byte beat is taken every cycle unless
// the pipe is full and stalled; a result passes the frame, multiply and
// output registers, and each stage holds only while the stage after it is
// full and stalled, so o_res backpressure reaches i_rx only once the whole
// pipe is full. Registers on i_cfg (0 type code, 1 offset, 2 scale, other
// indexes ignored) are always ready and should be written while idle.
module crlf_packet_servo_setpoint_decoder import cpsd_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cpsd_stream_if.sink   i_rx,
    cpsd_stream_if.sink   i_cfg,
    cpsd_stream_if.source o_res
);

    logic [7:0]  r_set_code;
    logic [15:0] r_offset;
    logic [15:0] r_scale;

    t_frame      w_frame;
    logic        w_rx_accept;

    logic        r_s1_valid;
    t_frame      r_s1;
    logic        r_s2_valid;
    t_status     r_s2_status;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_adv1;
    logic        w_adv2;
    logic        w_adv3;
    logic        w_x_ok;
    logic        w_y_ok;
    logic [15:0] w_x_part;
    logic [15:0] w_y_part;

    // Configuration: take every write, ignore unknown indexes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_code <= RST_SET_CODE;
            r_offset   <= RST_OFFSET;
            r_scale    <= RST_SCALE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                REG_SET_CODE: r_set_code <= i_cfg.data.wr_data[7:0];
                REG_OFFSET:   r_offset   <= i_cfg.data.wr_data;
                REG_SCALE:    r_scale    <= i_cfg.data.wr_data;
                default: begin
                end
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or its contents move on
    assign w_adv3 = !r_out_valid || o_res.ready;
    assign w_adv2 = !r_s2_valid || w_adv3;
    assign w_adv1 = !r_s1_valid || w_adv2;

    assign i_rx.ready  = w_adv1;
    assign w_rx_accept = i_rx.valid && w_adv1;

    // Framing and head storage
    cpsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_rx_accept),
        .i_byte     (i_rx.data.rx_byte),
        .i_set_code (r_set_code),
        .o_frame    (w_frame)
    );

    // Stage 1: hold the packet view at its end
    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1 <= w_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= w_frame.done;
        end
    end

    // Stage 2: classify and multiply each single in its own lane
    cpsd_lane u_lane_x (
        .i_clk   (i_clk),
        .i_en    (w_adv2),
        .i_bits  (r_s1.x_bits),
        .i_scale (r_scale),
        .o_ok    (w_x_ok),
        .o_part  (w_x_part)
    );

    cpsd_lane u_lane_y (
        .i_clk   (i_clk),
        .i_en    (w_adv2),
        .i_bits  (r_s1.y_bits),
        .i_scale (r_scale),
        .o_ok    (w_y_ok),
        .o_part  (w_y_part)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_status <= r_s1.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 3: shift out the fraction, add the offset, settle the status
    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            if (r_s2_status != ST_OK) begin
                r_out.status    <= r_s2_status;
                r_out.x_compare <= '0;
                r_out.y_compare <= '0;
            end else if (!(w_x_ok && w_y_ok)) begin
                r_out.status    <= ST_RANGE;
                r_out.x_compare <= '0;
                r_out.y_compare <= '0;
            end else begin
                r_out.status    <= ST_OK;
                r_out.x_compare <= {1'b0, r_offset} + {1'b0, w_x_part};
                r_out.y_compare <= {1'b0, r_offset} + {1'b0, w_y_part};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

/* design/cpsd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpsd_front import cpsd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_set_code,
    output t_frame          o_frame
);

    logic [7:0]       r_prev;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [7:0]       r_head [HEAD_DEPTH];
    logic [7:0]       w_view [HEAD_DEPTH];
    logic             w_end;

    // Head as it stands once this beat is stored
    always_comb begin
        for (int k = 0; k < HEAD_DEPTH; k++) begin
            w_view[k] = (r_len == LEN_W'(k)) ? i_byte : r_head[k];
        end
    end

    assign n_len = (r_len < LEN_MAX) ? r_len + 4'd1 : r_len;
    assign w_end = (r_prev == BYTE_CR) && (i_byte == BYTE_LF);

    always_comb begin
        o_frame.done   = i_accept && w_end;
        o_frame.x_bits = {w_view[1], w_view[2], w_view[3], w_view[4]};
        o_frame.y_bits = {w_view[5], w_view[6], w_view[7], w_view[8]};
        if (w_view[0] != i_set_code) begin
            o_frame.status = ST_TYPE;
        end else if (n_len < HEAD_LEN) begin
            o_frame.status = ST_SHORT;
        end else begin
            o_frame.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HEAD_DEPTH; k++) begin
            if (i_accept && r_len == LEN_W'(k)) begin
                r_head[k] <= i_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_len  <= '0;
        end else if (i_accept) begin
            r_prev <= i_byte;
            r_len  <= w_end ? '0 : n_len;
        end
    end

endmodule

`default_nettype wire

/* design/cpsd_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpsd_lane import cpsd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_bits,
    input  wire logic [15:0] i_scale,
    output logic             o_ok,
    output logic [15:0]      o_part
);

    logic              w_sign;
    logic [7:0]        w_expo;
    logic [22:0]       w_mant;
    logic              w_ok;
    logic              w_one;
    logic              w_mul;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_shifted;

    logic              r_ok;
    logic              r_one;
    logic              r_mul;
    logic [PROD_W-1:0] r_prod;
    logic [7:0]        r_shift;

    assign w_sign = i_bits[31];
    assign w_expo = i_bits[30:23];
    assign w_mant = i_bits[22:0];

    // In range: +/-0, positive subnormals, normals below one, and exactly one
    always_comb begin
        if (w_expo == EXP_ALL_ONES) begin
            w_ok = 1'b0;
        end else if (w_sign) begin
            w_ok = (w_expo == 8'd0) && (w_mant == 23'd0);
        end else begin
            w_ok = (w_expo < EXP_BIAS) || ((w_expo == EXP_BIAS) && (w_mant == 23'd0));
        end
    end

    assign w_one  = !w_sign && (w_expo == EXP_BIAS);
    assign w_mul  = !w_sign && (w_expo != 8'd0) && (w_expo < EXP_BIAS);
    assign w_prod = {24'd0, i_scale} * {16'd0, 1'b1, w_mant};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok    <= w_ok;
            r_one   <= w_one;
            r_mul   <= w_mul;
            r_prod  <= w_prod;
            r_shift <= EXP_FRAC_POS - w_expo;
        end
    end

    // Drop the fraction bits; the value is below one so 16 bits remain
    assign w_shifted = r_prod >> r_shift;
    assign o_ok      = r_ok;
    assign o_part    = r_one ? i_scale : (r_mul ? w_shifted[15:0] : 16'd0);

endmodule

`default_nettype wire
